FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash value and shared types for the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int QueueDepth = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} item_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[t];
	endfunction

	localparam logic [255:0] InitHash = {
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

	localparam logic [7:0] PadMarker = 8'h80;

endpackage

FILE: src/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with FIPS 180-4 SHA-256 and emits 32 digest bytes.
// ----------------------------------------------------------------------------
// Usage: the input channel is a queue write port. A transaction is accepted
// when push is high and full is low; it carries data_byte, byte_present and
// message_end. An item with message_end high closes the message (after
// appending its byte if byte_present is high), so an empty message is one
// transaction with byte_present low.
// The result channel is a queue read port. While empty is low the oldest
// digest byte is on digest_byte, with digest_last high on the 32nd byte,
// and pop takes it.
// Throughput: the core takes a plain byte whenever it is idle; the byte that
// completes a 64-byte block adds the one-round-per-cycle compression and the
// final hash add. Closing a message takes the padding, one or two compressions
// and then the digest, one byte per cycle while the receiver pops. A four-entry
// input queue decouples the producer from the core. When the receiver stalls
// the core holds the next digest byte and stops; the input queue then fills.
// Reset clears the queues and loads the initial hash value.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
	parameter int QueueDepth = sha_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       message_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] digest_byte,
	output logic       digest_last
);
	sha_pkg::item_t in_item, item;
	logic           item_valid, item_take;

	assign in_item = '{data_byte: data_byte, byte_present: byte_present,
		message_end: message_end};

	sha_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.item_valid, .item_take, .item
	);

	sha_core u_core (
		.clk, .arst_n, .item_valid, .item_take, .item,
		.empty, .pop, .digest_byte, .digest_last
	);

endmodule

FILE: src/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front queue
// Accepts input transactions and holds them in a short queue for the core.
// ----------------------------------------------------------------------------
module sha_front #(
	parameter int Depth = sha_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  sha_pkg::item_t in_item,
	output logic           item_valid,
	input  logic           item_take,
	output sha_pkg::item_t item
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sha_pkg::item_t mem_q [Depth];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           do_push, do_pop;

	assign full       = (cnt_q == (AW+1)'(Depth));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

FILE: src/sha_core.sv
// ----------------------------------------------------------------------------
// SHA-256 core
// Packs bytes into message words, pads, compresses one round per cycle and
// streams the digest bytes out through a one-entry output register.
// ----------------------------------------------------------------------------
module sha_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_take,
	input  sha_pkg::item_t item,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     digest_byte,
	output logic           digest_last
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLen  = 3'd2;
	localparam logic [2:0] StComp = 3'd3;
	localparam logic [2:0] StAdd  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0]   state_q;
	logic [31:0]  w_q [16];      // message schedule window, word 0 is next
	logic [255:0] h_q;
	logic [255:0] v_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic [5:0]   rnd_q;
	logic         fin_q;         // this compression ends the message
	logic         after_q;       // padding continues after this compression
	logic [4:0]   oidx_q;
	logic         ovalid_q;
	logic [7:0]   obyte_q;
	logic         olast_q;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Shift one byte into the word window at the fill position.
	logic [31:0] cur_w;
	logic [31:0] new_w;
	logic [3:0]  wi;
	logic [7:0]  put_byte;
	logic        put_en;
	always_comb begin
		wi    = fill_q[5:2];
		cur_w = w_q[wi];
		new_w = cur_w;
		unique case (fill_q[1:0])
			2'd0: new_w = {put_byte, 24'd0};
			2'd1: new_w = {cur_w[31:24], put_byte, 16'd0};
			2'd2: new_w = {cur_w[31:16], put_byte, 8'd0};
			default: new_w = {cur_w[31:8], put_byte};
		endcase
	end

	// Round logic.
	logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wn;
	always_comb begin
		{a, b, c, d, e, f, g, hh} = v_q;
		t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ sha_pkg::round_k(rnd_q) + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	logic out_free;
	assign out_free  = !ovalid_q || pop;
	assign empty     = !ovalid_q;
	assign digest_byte = obyte_q;
	assign digest_last = olast_q;
	assign item_take = (state_q == StIdle);

	assign put_en   = (state_q == StIdle && item_valid && item.byte_present) ||
		(state_q == StPad);
	assign put_byte = (state_q == StPad) ? sha_pkg::PadMarker : item.data_byte;

	logic [7:0] sel_byte;
	always_comb begin
		sel_byte = h_q[255 - 8*oidx_q -: 8];
	end

	always_ff @(posedge clk) begin
		if (put_en) begin
			w_q[wi] <= new_w;
		end else if (state_q == StLen) begin
			// A wrapped first padding block is complete and keeps word 0.
			if (fill_q == 6'd56) begin
				w_q[14] <= len_q[63:32];
				w_q[15] <= len_q[31:0];
			end else if (fill_q[1:0] == 2'd0 && (fill_q != 6'd0 || after_q)) begin
				w_q[wi] <= '0;
			end
		end else if (state_q == StComp) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wn;
		end
		if (state_q == StComp) begin
			v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
		end else begin
			v_q <= h_q;
		end
		if (ovalid_q == 1'b0 || pop) begin
			obyte_q <= sel_byte;
			olast_q <= (oidx_q == 5'd31);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == StOut && out_free) begin
			ovalid_q <= 1'b1;
		end else if (pop && ovalid_q) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			h_q      <= sha_pkg::InitHash;
			fill_q   <= '0;
			len_q    <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			after_q  <= 1'b0;
			oidx_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (item_valid) begin
						if (item.byte_present) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'd8;
						end
						if (item.byte_present && fill_q == 6'd63) begin
							state_q <= StComp;
							rnd_q   <= '0;
							fin_q   <= 1'b0;
							after_q <= item.message_end;
						end else if (item.message_end) begin
							state_q <= StPad;
							after_q <= 1'b0;
						end
					end
				end
				StPad: begin
					fill_q  <= fill_q + 6'd1;
					state_q <= StLen;
				end
				StLen: begin
					// Zero one byte per cycle up to the length field or block end.
					if (fill_q == 6'd56) begin
						state_q <= StComp;
						rnd_q   <= '0;
						fin_q   <= 1'b1;
						fill_q  <= '0;
					end else if (fill_q == 6'd0 && !after_q) begin
						state_q <= StComp;
						rnd_q   <= '0;
						fin_q   <= 1'b0;
						after_q <= 1'b1;
					end else begin
						fill_q <= fill_q + 6'd1;
					end
				end
				StComp: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= StAdd;
					end
				end
				StAdd: begin
					h_q <= {h_q[255:224] + v_q[255:224], h_q[223:192] + v_q[223:192],
						h_q[191:160] + v_q[191:160], h_q[159:128] + v_q[159:128],
						h_q[127:96] + v_q[127:96], h_q[95:64] + v_q[95:64],
						h_q[63:32] + v_q[63:32], h_q[31:0] + v_q[31:0]};
					if (fin_q) begin
						state_q <= StOut;
						oidx_q  <= '0;
					end else if (after_q) begin
						// A whole number of blocks still needs its marker byte.
						state_q <= (len_q[8:0] == 9'd0) ? StPad : StLen;
					end else begin
						state_q <= StIdle;
					end
				end
				default: begin
					if (out_free) begin
						oidx_q   <= oidx_q + 5'd1;
						if (oidx_q == 5'd31) begin
							state_q <= StIdle;
							h_q     <= sha_pkg::InitHash;
							len_q   <= '0;
							fill_q  <= '0;
						end
					end
				end
			endcase
		end
	end

endmodule
